// File: hw/rtl/lzfd_pkg.sv
// Shared types and constants for the LZSS flag-byte decompressor.
`default_nettype none
package lzfd_pkg;

  localparam int unsigned HistDepth = 4096;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  localparam int unsigned OffsetW   = 12;
  localparam int unsigned LenCodeW  = 4;
  localparam int unsigned LenCntW   = 5;

  localparam logic [3:0] FlagItems = 4'd8;
  localparam logic [LenCntW-1:0] CopyRemBias = LenCntW'(2);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic                is_copy;
    logic [7:0]          lit;
    logic [OffsetW-1:0]  offset;
    logic [LenCodeW-1:0] len_code;
  } cmd_t;

  typedef enum logic {
    StIdle,
    StCopy
  } eng_state_e;

endpackage
`default_nettype wire

// File: hw/rtl/lzfd_parser.sv
// Front end: parses flag bytes, literals and codes into commands.
`default_nettype none
module lzfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          block_last_i,
  input  wire logic          fifo_full_i,
  output logic               push_o,
  output lzfd_pkg::cmd_t     cmd_o
);
  import lzfd_pkg::*;

  logic [7:0] flag_q, flag_d;
  logic [3:0] items_q, items_d;
  logic [7:0] low_q, low_d;
  logic       have_q, have_d;
  logic       accept;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  always_comb begin
    flag_d  = flag_q;
    items_d = items_q;
    low_d   = low_q;
    have_d  = have_q;
    push_o  = 1'b0;
    cmd_o.is_copy  = 1'b0;
    cmd_o.lit      = in_byte_i;
    cmd_o.offset   = {in_byte_i[3:0], low_q};
    cmd_o.len_code = in_byte_i[7:4];
    if (accept) begin
      if (items_q == 4'd0) begin
        flag_d  = in_byte_i;
        items_d = FlagItems;
        have_d  = 1'b0;
      end else if (!flag_q[0]) begin
        push_o  = 1'b1;
        flag_d  = flag_q >> 1;
        items_d = items_q - 4'd1;
      end else if (!have_q) begin
        low_d  = in_byte_i;
        have_d = 1'b1;
      end else begin
        push_o        = 1'b1;
        cmd_o.is_copy = 1'b1;
        have_d        = 1'b0;
        flag_d        = flag_q >> 1;
        items_d       = items_q - 4'd1;
      end
      if (block_last_i) begin
        items_d = 4'd0;
        have_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= '0;
      items_q <= '0;
      low_q   <= '0;
      have_q  <= 1'b0;
    end else begin
      flag_q  <= flag_d;
      items_q <= items_d;
      low_q   <= low_d;
      have_q  <= have_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzfd_cmd_fifo.sv
// Short command queue between the parser and the copy engine.
`default_nettype none
module lzfd_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  lzfd_pkg::cmd_t     cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output lzfd_pkg::cmd_t     cmd_o
);
  import lzfd_pkg::*;

  cmd_t                slot_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzfd_copy_engine.sv
// Back end: history memory, copy sequencer and output register.
`default_nettype none
module lzfd_copy_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  lzfd_pkg::cmd_t     cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o
);
  import lzfd_pkg::*;

  logic [7:0] mem [HistDepth];

  eng_state_e          state_q, state_d;
  logic [HistAw-1:0]   wp_q, wp_d;
  logic [HistAw-1:0]   src_q, src_d;
  logic [LenCntW-1:0]  rd_left_q, rd_left_d;
  logic [7:0]          mem_rd_q;
  logic                fwd_q;
  logic [7:0]          fwd_byte_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;

  logic                adv;
  logic                emit;
  logic [7:0]          emit_byte;
  logic                emit_last;
  logic                re;
  logic [HistAw-1:0]   raddr;
  logic [7:0]          rd_byte;

  assign adv     = !out_valid_q || out_ready_i;
  assign rd_byte = fwd_q ? fwd_byte_q : mem_rd_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && adv && cmd_i.is_copy) begin
          state_d = StCopy;
        end
      end
      StCopy: begin
        if (adv && rd_left_q == '0) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_byte = cmd_i.lit;
    emit_last = 1'b1;
    re        = 1'b0;
    raddr     = src_q;
    src_d     = src_q;
    rd_left_d = rd_left_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && adv) begin
          pop_o = 1'b1;
          if (cmd_i.is_copy) begin
            re        = 1'b1;
            raddr     = wp_q - HistAw'(cmd_i.offset) - HistAw'(1);
            src_d     = raddr + HistAw'(1);
            rd_left_d = LenCntW'(cmd_i.len_code) + CopyRemBias;
          end else begin
            emit = 1'b1;
          end
        end
      end
      StCopy: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = rd_byte;
          emit_last = (rd_left_q == '0);
          if (rd_left_q != '0) begin
            re        = 1'b1;
            raddr     = src_q;
            src_d     = src_q + HistAw'(1);
            rd_left_d = rd_left_q - LenCntW'(1);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    wp_d = emit ? wp_q + HistAw'(1) : wp_q;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem[wp_q] <= emit_byte;
    end
    if (re) begin
      mem_rd_q   <= mem[raddr];
      fwd_q      <= emit && (raddr == wp_q);
      fwd_byte_q <= emit_byte;
    end
    if (adv && emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      src_q       <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      src_q     <= src_d;
      rd_left_q <= rd_left_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_copy_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy && adv) |=> out_valid_q)
    else $error("copy cycle did not produce an output byte");

  a_literal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && cmd_valid_i && adv && !cmd_i.is_copy) |=>
      (out_valid_q && out_last_q))
    else $error("literal was not emitted as the final byte of its transaction");

  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (wp_q == $past(wp_q) + HistAw'(1)))
    else $error("write pointer did not advance by one on an emitted byte");

  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy && adv && rd_left_q == '0) |=>
      (state_q == StIdle && out_last_q))
    else $error("copy did not end with a final byte");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/lz77_flag_byte_decompressor_unit.sv
// Top level of the LZSS flag-byte decompressor with 12-bit offsets and 4-bit lengths.
// Usage:
// The input channel takes one compressed byte per transaction, with block_last_i
// marking the final byte of a block; the parser then expects a flag byte again.
// The output channel delivers one decompressed byte per transaction, and run_last_o
// marks the final byte produced by one input transaction.
// Flag bytes and code low bytes produce no output. A literal passes the command
// queue and the output register; a copy's first byte passes the queue, the history
// read register and the output register. Literals sustain one byte per cycle while
// the receiver does not stall; a copy of length L (3 to 18) occupies the copy engine
// until its last byte, set by the single read port of the 4096-byte history memory.
// A two-entry command queue separates the parser from the copy engine, so input
// is taken while a copy drains until the queue is full.
// Reset clears the parser, the queue, the write pointer and the output valid flag;
// history contents are not cleared and only written bytes may be referenced.
// When the receiver stalls, the output byte holds and the copy engine pauses.
`default_nettype none
module lz77_flag_byte_decompressor_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       block_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);
  import lzfd_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic fifo_full;
  logic head_valid;
  logic pop;

  lzfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .block_last_i (block_last_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  lzfd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  lzfd_copy_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule
`default_nettype wire

// File: bench/lzfd_stream_checker.sv
// Checker for the decompressor: watches both channels, predicts each output byte and compares.
module lzfd_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       block_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  output int         errors_o,
  output int         pending_o
);
  import lzfd_pkg::*;

  localparam int unsigned MinCopyLen = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  out_beat_t         expected_bytes_q[$];
  out_beat_t         head_beat;
  logic [7:0]        hist_mem [HistDepth];
  logic [HistAw-1:0] wr_ptr = '0;
  logic [7:0]        flag_bits = '0;
  logic [3:0]        items_left = '0;
  logic [7:0]        code_low = '0;
  logic              have_low = 1'b0;
  int                error_count = 0;

  task automatic emit_byte(input logic [7:0] b, input logic last);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    expected_bytes_q.push_back({b, last});
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [OffsetW-1:0] offset;
    logic [LenCntW-1:0] len;
    if (items_left == 4'd0) begin
      flag_bits  = b;
      items_left = FlagItems;
      have_low   = 1'b0;
    end else if (!flag_bits[0]) begin
      emit_byte(b, 1'b1);
      flag_bits  = flag_bits >> 1;
      items_left = items_left - 1'b1;
    end else if (!have_low) begin
      code_low = b;
      have_low = 1'b1;
    end else begin
      offset = {b[3:0], code_low};
      len    = LenCntW'(b[7:4]) + LenCntW'(MinCopyLen);
      for (int i = 0; i < len; i++) begin
        emit_byte(hist_mem[wr_ptr - offset - 1'b1], i == len - 1);
      end
      have_low   = 1'b0;
      flag_bits  = flag_bits >> 1;
      items_left = items_left - 1'b1;
    end
    if (last) begin
      items_left = 4'd0;
      have_low   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr     = '0;
      flag_bits  = '0;
      items_left = '0;
      code_low   = '0;
      have_low   = 1'b0;
      expected_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes_q.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_byte_i);
          error_count++;
        end else begin
          head_beat = expected_bytes_q.pop_front();
          if (out_byte_i !== head_beat.data) begin
            $error("out_byte: expected %02h, actual %02h", head_beat.data, out_byte_i);
            error_count++;
          end
          if (run_last_i !== head_beat.last) begin
            $error("run_last: expected %0b, actual %0b", head_beat.last, run_last_i);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_byte_i, block_last_i);
      end
      errors_o  <= error_count;
      pending_o <= expected_bytes_q.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the decompressor testbench: clock, reset, compressed stream stimulus and the verdict.
module testbench;
  import lzfd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       block_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  int         errors;
  int         pending;
  int         cyc = 0;
  int         items_sent = 0;
  int         copies_sent = 0;
  int         written_total = 0;
  logic       quiet;

  assign quiet = (cyc >= 500) && (cyc < 1300);

  lz77_flag_byte_decompressor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .block_last_i(block_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .run_last_o  (run_last)
  );

  lzfd_stream_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_byte_i   (in_byte),
    .block_last_i(block_last),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_byte_i  (out_byte),
    .run_last_i  (run_last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    out_ready <= quiet || ($urandom_range(99) >= 31);
  end

  task automatic send(input logic [7:0] b, input logic last, input int adds);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    block_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    written_total += adds;
    if (adds > 1) copies_sent++;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(12, 3);
    for (int k = 0; k < n; k++) begin
      send(8'($urandom), (k == n - 1) || ($urandom_range(9) == 0), 0);
    end
  endtask

  task automatic send_group();
    logic [7:0]  flag;
    logic [7:0]  blk_byte [17];
    int          blk_adds [17];
    int          n;
    int          cut;
    int          proj;
    int unsigned avail;
    logic [11:0] offset;
    logic [3:0]  lcode;
    bit          broken;
    bit          end_blk;
    flag = 8'($urandom) | 8'($urandom);
    blk_byte[0] = flag;
    blk_adds[0] = 0;
    n = 1;
    proj = written_total;
    for (int i = 0; i < 8; i++) begin
      if (!flag[i]) begin
        blk_byte[n] = 8'($urandom);
        blk_adds[n] = 1;
        n++;
        proj++;
      end else begin
        avail = (proj > HistDepth) ? HistDepth : proj;
        case ($urandom_range(3))
          0:       offset = 12'd0;
          1:       offset = 12'(avail - 1);
          default: offset = 12'($urandom_range(avail - 1));
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: lcode = 4'hF;
          4:          lcode = 4'h0;
          default:    lcode = 4'($urandom_range(15));
        endcase
        blk_byte[n]     = offset[7:0];
        blk_adds[n]     = 0;
        blk_byte[n + 1] = {lcode, offset[11:8]};
        blk_adds[n + 1] = int'(lcode) + 3;
        n += 2;
        proj += int'(lcode) + 3;
      end
    end
    broken  = ($urandom_range(9) == 0);
    end_blk = ($urandom_range(2) == 0);
    cut = broken ? $urandom_range(n - 1) : n - 1;
    for (int k = 0; k <= cut; k++) begin
      send(blk_byte[k], broken ? (k == cut) : ((k == n - 1) && end_blk), blk_adds[k]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-literal group, then a group of all codes including a self-overlapping
    // copy, the longest copy and a low byte that a block end cuts off.
    send(8'h00, 1'b0, 0);
    send(8'h00, 1'b0, 1);
    send(8'hFF, 1'b0, 1);
    send(8'hA5, 1'b0, 1);
    send(8'h5A, 1'b0, 1);
    send(8'h01, 1'b0, 1);
    send(8'h80, 1'b0, 1);
    send(8'h7F, 1'b0, 1);
    send(8'hFE, 1'b0, 1);
    send(8'hFF, 1'b0, 0);
    send(8'h00, 1'b0, 0);
    send(8'h00, 1'b0, 3);
    send(8'h07, 1'b0, 0);
    send(8'hF0, 1'b0, 18);
    send(8'h03, 1'b1, 0);
    // A flag byte that ends its block, a copy on the last byte of a block,
    // and a literal that ends its block.
    send(8'h55, 1'b1, 0);
    send(8'h02, 1'b0, 0);
    send(8'h3C, 1'b0, 1);
    send(8'h02, 1'b0, 0);
    send(8'h80, 1'b1, 11);
    send(8'h00, 1'b0, 0);
    send(8'hC3, 1'b1, 1);

    while (items_sent < 312) begin
      if (written_total >= HistDepth && $urandom_range(11) == 0) begin
        send_noise();
      end else begin
        send_group();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d input transactions, %0d back-reference copies,", items_sent,
             copies_sent);
    $display("and at least %0d output bytes with overlapping copies and block-end cuts",
             written_total);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lzfd_pkg.sv
hw/rtl/lzfd_parser.sv
hw/rtl/lzfd_cmd_fifo.sv
hw/rtl/lzfd_copy_engine.sv
hw/rtl/lz77_flag_byte_decompressor_unit.sv
bench/lzfd_stream_checker.sv
bench/testbench.sv
